### rtl/mlbl_pkg.sv
// ----------------------------------------------------------------------------
// mlbl_pkg
// Shared constants, types and helper functions of the max-log bit LLR block.
// ----------------------------------------------------------------------------
package mlbl_pkg;

  localparam int BITS_PER_SYMBOL = 2;
  localparam int MEMORY_LENGTH   = 3;
  localparam int STATES          = 16;
  localparam int METRIC_WIDTH    = 16;

  localparam int STATE_W   = $clog2(STATES);
  localparam int STEP_W    = 12;
  localparam int SUM_W     = METRIC_WIDTH + 1;
  localparam int DIFF_W    = SUM_W + 1;
  localparam int LLR_W     = 18;
  localparam int BIT_IDX_W = 2;
  localparam int BIT_CNT_W = (BITS_PER_SYMBOL > 1) ? $clog2(BITS_PER_SYMBOL) : 1;
  localparam int WORK_W    = (DIFF_W > LLR_W) ? DIFF_W : LLR_W;

  typedef logic signed [METRIC_WIDTH-1:0] metric_t;
  typedef logic signed [SUM_W-1:0]        sum_t;
  typedef logic signed [LLR_W-1:0]        llr_t;
  typedef logic signed [WORK_W-1:0]       work_t;

  localparam llr_t  LLR_POS = {1'b0, {(LLR_W-1){1'b1}}};
  localparam llr_t  LLR_NEG = {1'b1, {(LLR_W-1){1'b0}}};
  localparam sum_t  SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam work_t WORK_POS = WORK_W'(LLR_POS);
  localparam work_t WORK_NEG = WORK_W'(LLR_NEG);

  // One registered state sample handed from the front end to the accumulator.
  typedef struct packed {
    logic               valid;
    logic               last;
    logic               counted;
    logic [STATE_W-1:0] state;
    sum_t               sum;
  } sample_t;

  // Early in the frame only states on a coarse stride are reachable.
  function automatic logic counted_f(input logic [STATE_W-1:0] state,
                                     input logic [STEP_W-1:0]  step);
    int   sh;
    int   stride;
    logic res;
    res = 1'b1;
    if (int'(step) < MEMORY_LENGTH - 1) begin
      sh     = BITS_PER_SYMBOL * int'(step);
      stride = (sh >= 31) ? 0 : (STATES >> sh);
      if (stride < 1) begin
        stride = 1;
      end
      res = ((int'(state) & (stride - 1)) == 0);
    end
    return res;
  endfunction

  // True when the state index selects the one set of symbol bit m.
  function automatic logic is_one_f(input logic [STATE_W-1:0] state, input int m);
    int mask;
    mask = STATES >> (m + 1);
    return ((int'(state) & mask) != 0);
  endfunction

  function automatic llr_t sat_f(input work_t v);
    llr_t res;
    if (v > WORK_POS) begin
      res = LLR_POS;
    end else if (v < WORK_NEG) begin
      res = LLR_NEG;
    end else begin
      res = v[LLR_W-1:0];
    end
    return res;
  endfunction

endpackage

### rtl/mlbl_front.sv
// ----------------------------------------------------------------------------
// mlbl_front
// Input register: sums the metric pair, tracks state and time step counters
// and holds the frame length register.
// ----------------------------------------------------------------------------
module mlbl_front import mlbl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  metric_t           alpha_metric_i,
  input  metric_t           beta_metric_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [STEP_W-1:0] cfg_data_i,
  input  logic              stall_i,
  output sample_t           sample_o
);

  logic [STEP_W-1:0]  frame_len_q;
  logic [STATE_W-1:0] state_q, state_d;
  logic [STEP_W-1:0]  step_q, step_d;
  sample_t            sample_q, sample_d;
  logic               accept;
  logic               last;

  assign in_ready_o  = !stall_i;
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && !stall_i;
  assign last        = (state_q == STATE_W'(STATES - 1));

  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    sample_d = sample_q;
    if (!stall_i) begin
      sample_d.valid = in_valid_i;
    end
    if (accept) begin
      sample_d.last    = last;
      sample_d.counted = counted_f(state_q, step_q);
      sample_d.state   = state_q;
      sample_d.sum     = SUM_W'(alpha_metric_i) + SUM_W'(beta_metric_i);
      if (last) begin
        state_d = '0;
        // The step counter wraps to the first step at the end of a frame.
        if (step_q >= frame_len_q) begin
          step_d = STEP_W'(1);
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end else begin
        state_d = state_q + STATE_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_len_q <= STEP_W'(1);
      state_q     <= '0;
      step_q      <= STEP_W'(1);
      sample_q    <= '0;
    end else begin
      if (cfg_valid_i) begin
        frame_len_q <= cfg_data_i;
      end
      state_q  <= state_d;
      step_q   <= step_d;
      sample_q <= sample_d;
    end
  end

  assign sample_o = sample_q;

endmodule

### rtl/mlbl_accum.sv
// ----------------------------------------------------------------------------
// mlbl_accum
// Running maxima of the zero and one sets for every symbol bit, and the
// LLR of each bit at the end of a time step.
// ----------------------------------------------------------------------------
module mlbl_accum import mlbl_pkg::*; (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sample_t                           sample_i,
  input  logic                              out_busy_i,
  output logic                              stall_o,
  output logic                              load_o,
  output llr_t [BITS_PER_SYMBOL-1:0]        llr_o
);

  sum_t [BITS_PER_SYMBOL-1:0] best_zero_q, best_zero_d;
  sum_t [BITS_PER_SYMBOL-1:0] best_one_q, best_one_d;
  logic [BITS_PER_SYMBOL-1:0] seen_zero_q, seen_zero_d;
  logic [BITS_PER_SYMBOL-1:0] seen_one_q, seen_one_d;
  logic                       upd;
  logic                       take;

  // The last state of a step waits until the result buffer is free.
  assign stall_o = sample_i.valid && sample_i.last && out_busy_i;
  assign upd     = sample_i.valid && !stall_o;
  assign take    = upd && sample_i.counted;
  assign load_o  = upd && sample_i.last;

  always_comb begin
    best_zero_d = best_zero_q;
    best_one_d  = best_one_q;
    seen_zero_d = seen_zero_q;
    seen_one_d  = seen_one_q;
    for (int m = 0; m < BITS_PER_SYMBOL; m++) begin
      if (take) begin
        if (is_one_f(sample_i.state, m)) begin
          if (!seen_one_q[m] || (sample_i.sum > best_one_q[m])) begin
            best_one_d[m] = sample_i.sum;
          end
          seen_one_d[m] = 1'b1;
        end else begin
          if (!seen_zero_q[m] || (sample_i.sum > best_zero_q[m])) begin
            best_zero_d[m] = sample_i.sum;
          end
          seen_zero_d[m] = 1'b1;
        end
      end
      // An empty set drives the LLR to the matching rail.
      if (seen_zero_d[m] && seen_one_d[m]) begin
        llr_o[m] = sat_f(WORK_W'(best_zero_d[m]) - WORK_W'(best_one_d[m]));
      end else if (seen_zero_d[m]) begin
        llr_o[m] = LLR_POS;
      end else if (seen_one_d[m]) begin
        llr_o[m] = LLR_NEG;
      end else begin
        llr_o[m] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_zero_q <= {BITS_PER_SYMBOL{SUM_MIN}};
      best_one_q  <= {BITS_PER_SYMBOL{SUM_MIN}};
      seen_zero_q <= '0;
      seen_one_q  <= '0;
    end else if (load_o) begin
      best_zero_q <= {BITS_PER_SYMBOL{SUM_MIN}};
      best_one_q  <= {BITS_PER_SYMBOL{SUM_MIN}};
      seen_zero_q <= '0;
      seen_one_q  <= '0;
    end else begin
      best_zero_q <= best_zero_d;
      best_one_q  <= best_one_d;
      seen_zero_q <= seen_zero_d;
      seen_one_q  <= seen_one_d;
    end
  end

endmodule

### rtl/mlbl_out.sv
// ----------------------------------------------------------------------------
// mlbl_out
// Result register: holds the LLRs of one time step and hands them out one
// item per bit, most significant bit first.
// ----------------------------------------------------------------------------
module mlbl_out import mlbl_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  llr_t [BITS_PER_SYMBOL-1:0] llr_i,
  output logic                       busy_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output llr_t                       llr_o,
  output logic [BIT_IDX_W-1:0]       bit_index_o,
  output logic                       last_bit_o
);

  llr_t [BITS_PER_SYMBOL-1:0] llr_q;
  logic                       busy_q;
  logic [BIT_CNT_W-1:0]       cnt_q;
  logic                       final_bit;

  assign final_bit   = (cnt_q == BIT_CNT_W'(BITS_PER_SYMBOL - 1));
  assign busy_o      = busy_q;
  assign out_valid_o = busy_q;
  assign llr_o       = llr_q[cnt_q];
  assign bit_index_o = BIT_IDX_W'(cnt_q);
  assign last_bit_o  = final_bit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (load_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q && out_ready_i) begin
      if (final_bit) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + BIT_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      llr_q <= llr_i;
    end
  end

endmodule

### rtl/max_log_bit_llr_from_state_metrics.sv
// ----------------------------------------------------------------------------
// max_log_bit_llr_from_state_metrics
// Max-log bit LLRs from forward and backward trellis state metrics.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one item per state, alpha and beta metric of
//   that state, in state order for each trellis time step. One item can be
//   accepted in every clock cycle while in_ready_o is high.
//   After the last state of a step the block emits one item per symbol bit
//   on the output channel, bit 0 first, with last_bit set on the final one.
//   The first LLR of a step is valid once the last state has loaded the LLR
//   register from the input register; the others follow one per ready cycle.
//   The LLR register holds one step's results. If the receiver has not taken
//   them when the last state of the next step arrives, in_ready_o drops and
//   that state waits in the input register; otherwise inputs never stall.
//   The configuration channel writes the frame length (time steps per frame)
//   and is always ready; write it only while the block is idle.
//   Reset clears the state counter and the running maxima, sets the step
//   counter and the frame length to one and drops any pending result.
// ----------------------------------------------------------------------------
module max_log_bit_llr_from_state_metrics import mlbl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  metric_t              alpha_metric_i,
  input  metric_t              beta_metric_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [STEP_W-1:0]    cfg_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output llr_t                 llr_o,
  output logic [BIT_IDX_W-1:0] bit_index_o,
  output logic                 last_bit_o
);

  sample_t                    sample;
  logic                       stall;
  logic                       load;
  logic                       busy;
  llr_t [BITS_PER_SYMBOL-1:0] step_llr;

  mlbl_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .alpha_metric_i (alpha_metric_i),
    .beta_metric_i  (beta_metric_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .stall_i        (stall),
    .sample_o       (sample)
  );

  mlbl_accum u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sample_i   (sample),
    .out_busy_i (busy),
    .stall_o    (stall),
    .load_o     (load),
    .llr_o      (step_llr)
  );

  mlbl_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .llr_i       (step_llr),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .llr_o       (llr_o),
    .bit_index_o (bit_index_o),
    .last_bit_o  (last_bit_o)
  );

endmodule

### rtl/mlbl_checker.sv
// ----------------------------------------------------------------------------
// mlbl_checker
// Port-level checks of the max-log bit LLR block, bound to the top level.
// ----------------------------------------------------------------------------
module mlbl_checker import mlbl_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input llr_t                 llr_o,
  input logic [BIT_IDX_W-1:0] bit_index_o,
  input logic                 last_bit_o
);

  // A pending result may not be withdrawn or altered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(llr_o)
      && $stable(bit_index_o))
    else $error("output item changed while stalled");

  // Within a step the bit positions follow each other without a gap.
  a_bit_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_bit_o |=>
      out_valid_o && (bit_index_o == $past(bit_index_o) + BIT_IDX_W'(1)))
    else $error("bit index sequence broken");

  // The final item of a step carries the last bit position.
  a_last_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_bit_o == (bit_index_o == BIT_IDX_W'(BITS_PER_SYMBOL - 1))))
    else $error("last_bit does not match bit index");

  // Input back-pressure only comes from an unconsumed result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled without a pending result");

endmodule

bind max_log_bit_llr_from_state_metrics mlbl_checker u_mlbl_checker (.*);
